FILE: hw/rtl/avt_pkg.sv
// Shared types and constants for the affine vector transform block.
`default_nettype none

package avt_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ENTRY_COUNT   = 12;
	localparam int IDX_W         = 4;
	localparam int LANES         = 3;
	localparam int TERMS         = 3;
	// Exact sum of three 64-bit products plus scaled translation fits here
	localparam int SUM_W         = 2 * DATA_W + 2;

	typedef enum logic [1:0] {
		REQ_LOAD      = 2'd0,
		REQ_POINT     = 2'd1,
		REQ_ROTATE    = 2'd2,
		REQ_TRANSPOSE = 2'd3
	} req_type_t;

	// Coefficients one output lane needs for one item
	typedef struct packed {
		logic [TERMS-1:0][DATA_W-1:0] a;
		logic [DATA_W-1:0]            t;
	} lane_coef_t;

	// Stage load enables handed to each lane
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} stage_en_t;

endpackage

`default_nettype wire

FILE: hw/rtl/avt_mat_store.sv
// Matrix entry registers with load port and per-mode coefficient selection.
`default_nettype none

module avt_mat_store #(
	parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  wr_en,
	input  wire logic [avt_pkg::IDX_W-1:0]             wr_idx,
	input  wire logic [avt_pkg::DATA_W-1:0]            wr_data,
	input  wire avt_pkg::req_type_t                    mode,
	output avt_pkg::lane_coef_t [avt_pkg::LANES-1:0]   coef
);

	logic [avt_pkg::ENTRY_COUNT-1:0][avt_pkg::DATA_W-1:0] mat_q;

	// Entries reset to identity rotation, zero translation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < avt_pkg::ENTRY_COUNT; i++) begin
				if (i == 0 || i == 5 || i == 10) begin
					mat_q[i] <= avt_pkg::DATA_W'(1) << FRAC_BITS;
				end else begin
					mat_q[i] <= '0;
				end
			end
		end else if (wr_en && (wr_idx < avt_pkg::IDX_W'(avt_pkg::ENTRY_COUNT))) begin
			mat_q[wr_idx] <= wr_data;
		end
	end

	// Row-major for point/rotate, column-major for transpose
	always_comb begin
		for (int r = 0; r < avt_pkg::LANES; r++) begin
			for (int c = 0; c < avt_pkg::TERMS; c++) begin
				if (mode == avt_pkg::REQ_TRANSPOSE) begin
					coef[r].a[c] = mat_q[c * 4 + r];
				end else begin
					coef[r].a[c] = mat_q[r * 4 + c];
				end
			end
			coef[r].t = (mode == avt_pkg::REQ_POINT) ? mat_q[r * 4 + 3] : '0;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/avt_lane.sv
// One output component: multiply, two add stages, shift and saturate.
`default_nettype none

module avt_lane #(
	parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire avt_pkg::stage_en_t                         en,
	input  wire avt_pkg::lane_coef_t                        coef_s1,
	input  wire logic [avt_pkg::TERMS-1:0][avt_pkg::DATA_W-1:0] vec_s1,
	output logic [avt_pkg::DATA_W-1:0]                      out_s5,
	output logic                                            sat_s5
);

	localparam int PW = 2 * avt_pkg::DATA_W;
	localparam int SW = avt_pkg::SUM_W;
	localparam int DW = avt_pkg::DATA_W;

	logic signed [PW-1:0] prod [avt_pkg::TERMS];
	logic signed [SW-1:0] tsh;
	logic signed [PW-1:0] p_s2 [avt_pkg::TERMS];
	logic signed [SW-1:0] t_s2;
	logic signed [SW-1:0] ab_s3, ct_s3;
	logic signed [SW-1:0] sum_s4;
	logic signed [SW-1:0] shifted;
	logic                 fits;

	// Stage 2: full products, translation scaled up
	always_comb begin
		for (int k = 0; k < avt_pkg::TERMS; k++) begin
			prod[k] = PW'($signed(coef_s1.a[k])) * PW'($signed(vec_s1[k]));
		end
		tsh = SW'($signed(coef_s1.t)) <<< FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			for (int k = 0; k < avt_pkg::TERMS; k++) begin
				p_s2[k] <= prod[k];
			end
			t_s2 <= tsh;
		end
	end

	// Stage 3: pairwise sums
	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			ab_s3 <= SW'(p_s2[0]) + SW'(p_s2[1]);
			ct_s3 <= SW'(p_s2[2]) + t_s2;
		end
	end

	// Stage 4: final sum
	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			sum_s4 <= ab_s3 + ct_s3;
		end
	end

	// Stage 5: floor shift, clamp to 32 bits
	always_comb begin
		shifted = sum_s4 >>> FRAC_BITS;
		fits    = (&shifted[SW-1:DW-1]) || !(|shifted[SW-1:DW-1]);
	end

	always_ff @(posedge clk) begin
		if (en.en_s5) begin
			if (fits) begin
				out_s5 <= shifted[DW-1:0];
			end else if (shifted[SW-1]) begin
				out_s5 <= {1'b1, {(DW-1){1'b0}}};
			end else begin
				out_s5 <= {1'b0, {(DW-1){1'b1}}};
			end
			sat_s5 <= !fits;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/affine_vector_transform.sv
// Affine 3x4 matrix-vector transform: top level with pipeline control.
//
// Input channel (in_valid/in_ready) carries load items and vector items.
// A load item writes one matrix entry at its acceptance edge and yields no
// result; indexes above eleven are ignored. A vector item (point, rotate,
// transpose rotate) reads the matrix as it stands at its acceptance edge,
// so loads and vectors take effect strictly in item order.
// Output channel (out_valid/out_ready) returns one result per vector item:
// three saturated Q16.16 components and sat_flag.
// Throughput: one item per cycle while the receiver does not stall. A vector
// item passes through coefficient capture, multiply, two adder stages, and
// shift and clamp into the output register.
// Reset clears all stage valid bits and loads the identity rotation with
// zero translation. When the receiver stalls, results hold in place and
// stages fill behind them; in_ready drops only once every stage is full.
`default_nettype none

module affine_vector_transform #(
	parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    req_type,
	input  wire logic [avt_pkg::IDX_W-1:0]     entry_index,
	input  wire logic [avt_pkg::DATA_W-1:0]    entry_value,
	input  wire logic [avt_pkg::DATA_W-1:0]    vec_x,
	input  wire logic [avt_pkg::DATA_W-1:0]    vec_y,
	input  wire logic [avt_pkg::DATA_W-1:0]    vec_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [avt_pkg::DATA_W-1:0]         out_x,
	output logic [avt_pkg::DATA_W-1:0]         out_y,
	output logic [avt_pkg::DATA_W-1:0]         out_z,
	output logic                               sat_flag
);

	avt_pkg::req_type_t                         mode;
	avt_pkg::lane_coef_t [avt_pkg::LANES-1:0]   coef;
	avt_pkg::lane_coef_t [avt_pkg::LANES-1:0]   coef_s1;
	logic [avt_pkg::TERMS-1:0][avt_pkg::DATA_W-1:0] vec_s1;
	logic [avt_pkg::LANES-1:0][avt_pkg::DATA_W-1:0] res_s5;
	logic [avt_pkg::LANES-1:0]                  sat_s5;
	logic                                       v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                                       en_s1;
	avt_pkg::stage_en_t                         en;
	logic                                       accept, is_load;

	assign mode    = avt_pkg::req_type_t'(req_type);
	assign is_load = (mode == avt_pkg::REQ_LOAD);

	// A stage loads when it is empty or its successor loads
	always_comb begin
		en.en_s5 = !v_s5 || out_ready;
		en.en_s4 = !v_s4 || en.en_s5;
		en.en_s3 = !v_s3 || en.en_s4;
		en.en_s2 = !v_s2 || en.en_s3;
		en_s1    = !v_s1 || en.en_s2;
	end

	assign in_ready = en_s1;
	assign accept   = in_valid && in_ready;

	avt_mat_store #(
		.FRAC_BITS (FRAC_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && is_load),
		.wr_idx  (entry_index),
		.wr_data (entry_value),
		.mode    (mode),
		.coef    (coef)
	);

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1)    v_s1 <= accept && !is_load;
			if (en.en_s2) v_s2 <= v_s1;
			if (en.en_s3) v_s3 <= v_s2;
			if (en.en_s4) v_s4 <= v_s3;
			if (en.en_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: capture selected coefficients and the vector
	always_ff @(posedge clk) begin
		if (en_s1) begin
			coef_s1 <= coef;
			vec_s1  <= {vec_z, vec_y, vec_x};
		end
	end

	for (genvar g = 0; g < avt_pkg::LANES; g++) begin : g_lane
		avt_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.en      (en),
			.coef_s1 (coef_s1[g]),
			.vec_s1  (vec_s1),
			.out_s5  (res_s5[g]),
			.sat_s5  (sat_s5[g])
		);
	end

	assign out_valid = v_s5;
	assign out_x     = res_s5[0];
	assign out_y     = res_s5[1];
	assign out_z     = res_s5[2];
	assign sat_flag  = |sat_s5;

endmodule

`default_nettype wire

FILE: dv/affine_vector_transform_check.sv
// Checker for affine_vector_transform: tracks the matrix, predicts each result and compares.
module affine_vector_transform_check #(
	parameter int FRAC = avt_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [3:0]  entry_index,
	input  wire logic [31:0] entry_value,
	input  wire logic [31:0] vec_x,
	input  wire logic [31:0] vec_y,
	input  wire logic [31:0] vec_z,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] out_x,
	input  wire logic [31:0] out_y,
	input  wire logic [31:0] out_z,
	input  wire logic        sat_flag,
	output int               mismatches,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        sat;
	} vec_result_t;

	localparam logic signed [67:0] Q_MAX = 68'sd2147483647;
	localparam logic signed [67:0] Q_MIN = -68'sd2147483648;

	// Local copy of the matrix, row-major
	logic [31:0] coef [avt_pkg::ENTRY_COUNT];
	vec_result_t transformed_q [$];

	// One output lane: exact dot product plus scaled translation, floor shift, clamp.
	// Returns {saturated, value}.
	function automatic logic [32:0] lane_value(logic signed [31:0] c0, logic signed [31:0] c1,
			logic signed [31:0] c2, logic signed [31:0] t, logic signed [31:0] vx,
			logic signed [31:0] vy, logic signed [31:0] vz);
		logic signed [67:0] acc;
		logic signed [67:0] shifted;
		acc = 68'(c0) * 68'(vx) + 68'(c1) * 68'(vy) + 68'(c2) * 68'(vz) + (68'(t) <<< FRAC);
		shifted = acc >>> FRAC;
		if (shifted > Q_MAX)
			return {1'b1, 32'h7FFF_FFFF};
		if (shifted < Q_MIN)
			return {1'b1, 32'h8000_0000};
		return {1'b0, shifted[31:0]};
	endfunction

	function automatic vec_result_t transform_vector(avt_pkg::req_type_t kind,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
		vec_result_t r;
		logic [32:0] lane [avt_pkg::LANES];
		for (int k = 0; k < avt_pkg::LANES; k++) begin
			if (kind == avt_pkg::REQ_TRANSPOSE) begin
				lane[k] = lane_value(coef[k], coef[4 + k], coef[8 + k], '0, vx, vy, vz);
			end else begin
				lane[k] = lane_value(coef[4 * k], coef[4 * k + 1], coef[4 * k + 2],
						(kind == avt_pkg::REQ_POINT) ? coef[4 * k + 3] : '0, vx, vy, vz);
			end
		end
		r.x = lane[0][31:0];
		r.y = lane[1][31:0];
		r.z = lane[2][31:0];
		r.sat = lane[0][32] | lane[1][32] | lane[2][32];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vec_result_t want;
		if (!arst_n) begin
			// identity rotation, zero translation
			for (int i = 0; i < avt_pkg::ENTRY_COUNT; i++)
				coef[i] = (i == 0 || i == 5 || i == 10) ? (32'd1 << FRAC) : 32'd0;
			transformed_q.delete();
			mismatches = 0;
		end else begin
			// accepted input item: loads update the matrix, vectors queue a prediction
			if (in_valid && in_ready) begin
				if (avt_pkg::req_type_t'(req_type) == avt_pkg::REQ_LOAD) begin
					if (entry_index < avt_pkg::ENTRY_COUNT)
						coef[entry_index] = entry_value;
				end else begin
					transformed_q.push_back(transform_vector(
							avt_pkg::req_type_t'(req_type), vec_x, vec_y, vec_z));
				end
			end
			// accepted result item: compare against the oldest prediction
			if (out_valid && out_ready) begin
				if (transformed_q.size() == 0) begin
					$error("result item with no vector item outstanding");
					mismatches++;
				end else begin
					want = transformed_q.pop_front();
					if (out_x !== want.x) begin
						$error("out_x: expected %h, got %h", want.x, out_x);
						mismatches++;
					end
					if (out_y !== want.y) begin
						$error("out_y: expected %h, got %h", want.y, out_y);
						mismatches++;
					end
					if (out_z !== want.z) begin
						$error("out_z: expected %h, got %h", want.z, out_z);
						mismatches++;
					end
					if (sat_flag !== want.sat) begin
						$error("sat_flag: expected %b, got %b", want.sat, sat_flag);
						mismatches++;
					end
				end
			end
		end
		pending = transformed_q.size();
	end

endmodule

FILE: dv/affine_vector_transform_test.sv
// Testbench top for affine_vector_transform: clock, reset, item stimulus and verdict.
module affine_vector_transform_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1700;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [3:0]  entry_index;
	logic [31:0] entry_value;
	logic [31:0] vec_x;
	logic [31:0] vec_y;
	logic [31:0] vec_z;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [31:0] out_z;
	logic        sat_flag;
	int          mismatches;
	int          pending;

	// percent chance of an idle burst before an item / a stall burst on the output
	int in_idle_pct = 0;
	int out_stall_pct = 0;

	// extreme matrix used by the directed part
	logic [31:0] corner_coef [avt_pkg::ENTRY_COUNT] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
		32'h8000_0000, 32'h0001_0000, 32'h0000_0000, 32'h8000_0000,
		32'h0000_8000, 32'hFFFF_0000, 32'h8000_0000, 32'h0000_0001
	};

	affine_vector_transform dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .entry_index(entry_index), .entry_value(entry_value),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .sat_flag(sat_flag)
	);

	affine_vector_transform_check #(.FRAC(avt_pkg::FRAC_BITS_DEF)) u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .entry_index(entry_index), .entry_value(entry_value),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .sat_flag(sat_flag),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Q16.16 value with mixed magnitudes so both exact and clamped results occur
	function automatic logic [31:0] pick_q16();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2: return r;
			3, 4, 5, 9: return {{13{r[18]}}, r[18:0]};
			6, 7: return {{7{r[24]}}, r[24:0]};
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					4: return 32'h0001_0000;
					default: return 32'hFFFF_0000;
				endcase
			end
		endcase
	endfunction

	// Present one item, with an optional idle burst ahead of it, and wait for acceptance
	task automatic send_item(avt_pkg::req_type_t kind, logic [3:0] idx, logic [31:0] value,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= kind;
		entry_index <= idx;
		entry_value <= value;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Hold off the sender until every outstanding result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Output backpressure in random bursts
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
				hold = $urandom_range(1, 5) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = avt_pkg::REQ_LOAD;
		entry_index = '0;
		entry_value = '0;
		vec_x = '0;
		vec_y = '0;
		vec_z = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: identity matrix after reset, all three vector modes, point and rotate at the extremes
		send_item(avt_pkg::REQ_POINT, 4'($urandom), $urandom,
				32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		send_item(avt_pkg::REQ_ROTATE, 4'($urandom), $urandom,
				32'hFFFF_FFFF, 32'h0, 32'h0001_0000);
		send_item(avt_pkg::REQ_TRANSPOSE, 4'($urandom), $urandom,
				$urandom, $urandom, $urandom);
		// out-of-range loads must leave the matrix alone
		send_item(avt_pkg::REQ_LOAD, 4'd15, 32'h1234_5678, $urandom, $urandom, $urandom);
		send_item(avt_pkg::REQ_LOAD, 4'd12, 32'h8000_0000, $urandom, $urandom, $urandom);
		send_item(avt_pkg::REQ_POINT, 4'($urandom), $urandom,
				32'h0001_8000, 32'hFFFE_0000, 32'h7FFF_FFFF);
		// extreme matrix, then a vector in each mode
		for (int i = 0; i < avt_pkg::ENTRY_COUNT; i++)
			send_item(avt_pkg::REQ_LOAD, 4'(i), corner_coef[i], $urandom, $urandom, $urandom);
		send_item(avt_pkg::REQ_POINT, 4'($urandom), $urandom, 32'h0, 32'h0, 32'h0);
		send_item(avt_pkg::REQ_POINT, 4'($urandom), $urandom,
				32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(avt_pkg::REQ_POINT, 4'($urandom), $urandom,
				32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_item(avt_pkg::REQ_ROTATE, 4'($urandom), $urandom,
				32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_item(avt_pkg::REQ_TRANSPOSE, 4'($urandom), $urandom,
				32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		wait_drained();

		// Random: mostly vectors, with matrix entries reloaded now and then
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 200 == 0) begin
				case ((n / 200) % 4)
					0: begin in_idle_pct = 30; out_stall_pct = 30; end
					1: begin in_idle_pct = 0; out_stall_pct = 0; end
					2: begin in_idle_pct = 0; out_stall_pct = 50; end
					default: begin in_idle_pct = 50; out_stall_pct = 0; end
				endcase
				// the last stretch runs without any idling
				if (n >= 1500) begin
					in_idle_pct = 0;
					out_stall_pct = 0;
				end
			end
			if (n == 800)
				wait_drained();
			if ($urandom_range(0, 99) < 15) begin
				send_item(avt_pkg::REQ_LOAD,
						($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
								: 4'($urandom_range(0, 11)),
						pick_q16(), $urandom, $urandom, $urandom);
			end else begin
				send_item(avt_pkg::req_type_t'($urandom_range(1, 3)), 4'($urandom),
						$urandom, pick_q16(), pick_q16(), pick_q16());
			end
		end

		wait_drained();
		repeat (12) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/avt_pkg.sv
hw/rtl/avt_mat_store.sv
hw/rtl/avt_lane.sv
hw/rtl/affine_vector_transform.sv
dv/affine_vector_transform_check.sv
dv/affine_vector_transform_test.sv
